/* rtl/dcr_pkg.sv */
// Package for the disc collision response pipeline: stage map, widths, carried payload type
// and the saturation helper. Depends on nothing; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package dcr_pkg;

   // Fraction bits of the unit normal (Q2.28).
   localparam int FRAC_N = 28;

   // Iterations of the digit-serial units, one per pipeline stage.
   localparam int SQ_STEPS = 32;   // square root: one result bit per stage
   localparam int NQ_STEPS = 29;   // normal divide: quotient below 2^29
   localparam int KQ_STEPS = 36;   // impulse divide: quotient below 2^36

   localparam int NUM_W = 53;      // impulse numerator width

   // Stage map.
   localparam int ST_ABS   = 0;
   localparam int ST_SQ    = 1;
   localparam int ST_SUM   = 2;
   localparam int ST_SQRT0 = 3;
   localparam int ST_NDIV0 = ST_SQRT0 + SQ_STEPS;
   localparam int ST_PROD  = ST_NDIV0 + NQ_STEPS;
   localparam int ST_PN    = ST_PROD + 1;
   localparam int ST_DP    = ST_PN + 1;
   localparam int ST_NUM   = ST_DP + 1;
   localparam int ST_KDIV0 = ST_NUM + 1;
   localparam int ST_KPROD = ST_KDIV0 + KQ_STEPS;
   localparam int ST_OUT   = ST_KPROD + 1;
   localparam int DEPTH    = ST_OUT + 1;

   // Fields that travel with a transaction down the whole pipeline.
   typedef struct packed {
      logic signed [31:0] v1x;
      logic signed [31:0] v1y;
      logic signed [31:0] v2x;
      logic signed [31:0] v2y;
      logic [15:0]        m1;
      logic [15:0]        m2;
      logic [16:0]        msum;
      logic               mov1;
      logic               mov2;
      logic               coin;
      logic               skip;
      logic               sx;
      logic               sy;
      logic [30:0]        ax;
      logic [30:0]        ay;
      logic [31:0]        len;
      logic signed [29:0] nx;
      logic signed [29:0] ny;
      logic               kn1;
      logic               kn2;
   } carry_type;

   // Clamp a 40-bit sum to the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sh007FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -40'sh0080000000) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/dcr_if.sv */
// Channel interfaces for the disc collision response block: request and response,
// each with valid, ready and payload. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface dcr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] first_pos_x;
   logic signed [31:0] first_pos_y;
   logic signed [31:0] first_vel_x;
   logic signed [31:0] first_vel_y;
   logic [15:0]        first_mass;
   logic               first_movable;
   logic signed [31:0] second_pos_x;
   logic signed [31:0] second_pos_y;
   logic signed [31:0] second_vel_x;
   logic signed [31:0] second_vel_y;
   logic [15:0]        second_mass;
   logic               second_movable;

   modport source (
      output valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
             first_movable, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
             second_mass, second_movable,
      input  ready
   );
   modport sink (
      input  valid, first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass,
             first_movable, second_pos_x, second_pos_y, second_vel_x, second_vel_y,
             second_mass, second_movable,
      output ready
   );
endinterface

interface dcr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_first_vel_x;
   logic signed [31:0] new_first_vel_y;
   logic signed [31:0] new_second_vel_x;
   logic signed [31:0] new_second_vel_y;
   logic               coincident;

   modport source (
      output valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
             new_second_vel_y, coincident,
      input  ready
   );
   modport sink (
      input  valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
             new_second_vel_y, coincident,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/disc_elastic_collision_response_top.sv */
// Pipeline: 106 register stages; a response transaction is offered on rsp_ch once its accepted
// request transaction has passed through all of them. The square root (32 stages), the normal divide (29)
// and the impulse divide (36) take most of them.
// Throughput: one transaction per cycle; a stalled response freezes the whole pipeline.
// Reset (synchronous, active high) clears every stage valid bit; the payload is not reset.
// Uses dcr_pkg and the dcr_req_if / dcr_rsp_if interfaces.
`timescale 1ns / 1ps
`default_nettype none

module disc_elastic_collision_response_top (
   input  wire logic clock,
   input  wire logic reset,
   dcr_req_if.sink   req_ch,
   dcr_rsp_if.source rsp_ch
);

   logic [dcr_pkg::DEPTH-1:0] valid_ff, valid_in;
   dcr_pkg::carry_type carry_ff [dcr_pkg::DEPTH];
   dcr_pkg::carry_type carry_in [dcr_pkg::DEPTH];

   // The whole pipeline moves together. It advances whenever the output register is empty
   // or its transaction is being taken, so a waiting response never blocks a new request
   // unless the sink itself is stalling.
   logic adv;
   assign adv          = rsp_ch.ready || !valid_ff[dcr_pkg::DEPTH-1];
   assign req_ch.ready = adv;

   assign valid_in = {valid_ff[dcr_pkg::DEPTH-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < dcr_pkg::DEPTH; s++) begin
            carry_ff[s] <= carry_in[s];
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Stage 0: centre difference, magnitudes and the halving that keeps both below 2^31.
   // Coincident centres, or two zero masses, mark the transaction for plain pass-through.
   // ------------------------------------------------------------------------------------
   logic signed [32:0] dx, dy;
   logic [32:0]        dx_mag, dy_mag;
   logic               halve;
   logic [16:0]        msum;
   logic [31:0]        len0;
   logic signed [29:0] nx_c, ny_c;
   logic signed [35:0] dp_ff;

   always_comb begin
      dx     = {req_ch.second_pos_x[31], req_ch.second_pos_x}
             - {req_ch.first_pos_x[31], req_ch.first_pos_x};
      dy     = {req_ch.second_pos_y[31], req_ch.second_pos_y}
             - {req_ch.first_pos_y[31], req_ch.first_pos_y};
      dx_mag = dx[32] ? 33'(-dx) : 33'(dx);
      dy_mag = dy[32] ? 33'(-dy) : 33'(dy);
      halve  = dx_mag[31] | dy_mag[31];
      msum   = {1'b0, req_ch.first_mass} + {1'b0, req_ch.second_mass};

      // Default: everything shifts one stage on.
      carry_in[0] = '0;
      for (int s = 1; s < dcr_pkg::DEPTH; s++) begin
         carry_in[s] = carry_ff[s-1];
      end

      carry_in[dcr_pkg::ST_ABS].v1x  = req_ch.first_vel_x;
      carry_in[dcr_pkg::ST_ABS].v1y  = req_ch.first_vel_y;
      carry_in[dcr_pkg::ST_ABS].v2x  = req_ch.second_vel_x;
      carry_in[dcr_pkg::ST_ABS].v2y  = req_ch.second_vel_y;
      carry_in[dcr_pkg::ST_ABS].m1   = req_ch.first_mass;
      carry_in[dcr_pkg::ST_ABS].m2   = req_ch.second_mass;
      carry_in[dcr_pkg::ST_ABS].msum = msum;
      carry_in[dcr_pkg::ST_ABS].mov1 = req_ch.first_movable;
      carry_in[dcr_pkg::ST_ABS].mov2 = req_ch.second_movable;
      carry_in[dcr_pkg::ST_ABS].coin = (dx == '0) && (dy == '0);
      carry_in[dcr_pkg::ST_ABS].skip = ((dx == '0) && (dy == '0)) || (msum == '0);
      carry_in[dcr_pkg::ST_ABS].sx   = dx[32];
      carry_in[dcr_pkg::ST_ABS].sy   = dy[32];
      carry_in[dcr_pkg::ST_ABS].ax   = halve ? dx_mag[31:1] : dx_mag[30:0];
      carry_in[dcr_pkg::ST_ABS].ay   = halve ? dy_mag[31:1] : dy_mag[30:0];

      // The divisor enters the normal divide; a zero root is forced to one.
      carry_in[dcr_pkg::ST_NDIV0].len = len0;

      // Signed unit normal from the divide quotients.
      carry_in[dcr_pkg::ST_PROD].nx = nx_c;
      carry_in[dcr_pkg::ST_PROD].ny = ny_c;

      // Sign of each impulse: k1 follows pn2 - pn1, k2 the opposite.
      carry_in[dcr_pkg::ST_NUM].kn1 = dp_ff[35];
      carry_in[dcr_pkg::ST_NUM].kn2 = ~dp_ff[35];
   end

   // ------------------------------------------------------------------------------------
   // Stages 1 and 2: squared length, one multiplier per component, then the sum.
   // ------------------------------------------------------------------------------------
   logic [61:0] sqa_ff, sqb_ff;
   logic [62:0] sum_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqa_ff <= carry_ff[dcr_pkg::ST_SQ-1].ax * carry_ff[dcr_pkg::ST_SQ-1].ax;
         sqb_ff <= carry_ff[dcr_pkg::ST_SQ-1].ay * carry_ff[dcr_pkg::ST_SQ-1].ay;
         sum_ff <= {1'b0, sqa_ff} + {1'b0, sqb_ff};
      end
   end

   // ------------------------------------------------------------------------------------
   // Integer square root: the classic bit-pair method, one result bit per stage.
   // ------------------------------------------------------------------------------------
   logic [63:0] sq_n_ff [dcr_pkg::SQ_STEPS];
   logic [63:0] sq_r_ff [dcr_pkg::SQ_STEPS];
   logic [63:0] sq_n_in [dcr_pkg::SQ_STEPS];
   logic [63:0] sq_r_in [dcr_pkg::SQ_STEPS];

   for (genvar j = 0; j < dcr_pkg::SQ_STEPS; j++) begin : g_sqrt
      localparam logic [63:0] BitV = 64'd1 << (62 - 2 * j);
      logic [63:0] n_cur, r_cur, trial;

      if (j == 0) begin : g_first
         assign n_cur = {1'b0, sum_ff};
         assign r_cur = '0;
      end else begin : g_next
         assign n_cur = sq_n_ff[j-1];
         assign r_cur = sq_r_ff[j-1];
      end

      always_comb begin
         trial = r_cur + BitV;
         if (n_cur >= trial) begin
            sq_n_in[j] = n_cur - trial;
            sq_r_in[j] = (r_cur >> 1) + BitV;
         end else begin
            sq_n_in[j] = n_cur;
            sq_r_in[j] = r_cur >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < dcr_pkg::SQ_STEPS; j++) begin
            sq_n_ff[j] <= sq_n_in[j];
            sq_r_ff[j] <= sq_r_in[j];
         end
      end
   end

   assign len0 = (sq_r_ff[dcr_pkg::SQ_STEPS-1][31:0] == '0) ? 32'd1
               : sq_r_ff[dcr_pkg::SQ_STEPS-1][31:0];

   // ------------------------------------------------------------------------------------
   // Normal divide: (|d| << 28) / len for both components, restoring, one quotient bit
   // per stage from the top. The quotient never exceeds 2^28.
   // ------------------------------------------------------------------------------------
   logic [59:0] nrx_ff [dcr_pkg::NQ_STEPS];
   logic [59:0] nry_ff [dcr_pkg::NQ_STEPS];
   logic [28:0] nqx_ff [dcr_pkg::NQ_STEPS];
   logic [28:0] nqy_ff [dcr_pkg::NQ_STEPS];
   logic [59:0] nrx_in [dcr_pkg::NQ_STEPS];
   logic [59:0] nry_in [dcr_pkg::NQ_STEPS];
   logic [28:0] nqx_in [dcr_pkg::NQ_STEPS];
   logic [28:0] nqy_in [dcr_pkg::NQ_STEPS];

   for (genvar j = 0; j < dcr_pkg::NQ_STEPS; j++) begin : g_ndiv
      localparam int Sh = dcr_pkg::NQ_STEPS - 1 - j;
      logic [59:0] rx_cur, ry_cur, dsh;
      logic [28:0] qx_cur, qy_cur;
      logic [31:0] len_cur;

      if (j == 0) begin : g_first
         assign rx_cur  = {1'b0, carry_ff[dcr_pkg::ST_NDIV0-1].ax, 28'd0};
         assign ry_cur  = {1'b0, carry_ff[dcr_pkg::ST_NDIV0-1].ay, 28'd0};
         assign qx_cur  = '0;
         assign qy_cur  = '0;
         assign len_cur = len0;
      end else begin : g_next
         assign rx_cur  = nrx_ff[j-1];
         assign ry_cur  = nry_ff[j-1];
         assign qx_cur  = nqx_ff[j-1];
         assign qy_cur  = nqy_ff[j-1];
         assign len_cur = carry_ff[dcr_pkg::ST_NDIV0+j-1].len;
      end

      always_comb begin
         dsh = {28'd0, len_cur} << Sh;
         if (rx_cur >= dsh) begin
            nrx_in[j] = rx_cur - dsh;
            nqx_in[j] = qx_cur | (29'd1 << Sh);
         end else begin
            nrx_in[j] = rx_cur;
            nqx_in[j] = qx_cur;
         end
         if (ry_cur >= dsh) begin
            nry_in[j] = ry_cur - dsh;
            nqy_in[j] = qy_cur | (29'd1 << Sh);
         end else begin
            nry_in[j] = ry_cur;
            nqy_in[j] = qy_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < dcr_pkg::NQ_STEPS; j++) begin
            nrx_ff[j] <= nrx_in[j];
            nry_ff[j] <= nry_in[j];
            nqx_ff[j] <= nqx_in[j];
            nqy_ff[j] <= nqy_in[j];
         end
      end
   end

   always_comb begin
      nx_c = {1'b0, nqx_ff[dcr_pkg::NQ_STEPS-1]};
      ny_c = {1'b0, nqy_ff[dcr_pkg::NQ_STEPS-1]};
      if (carry_ff[dcr_pkg::ST_PROD-1].sx) begin
         nx_c = -nx_c;
      end
      if (carry_ff[dcr_pkg::ST_PROD-1].sy) begin
         ny_c = -ny_c;
      end
   end

   // ------------------------------------------------------------------------------------
   // Normal projections: four products, then pn = floor(sum / 2^28), then pn2 - pn1,
   // then the unsigned impulse numerators 2 * m * |pn2 - pn1|.
   // ------------------------------------------------------------------------------------
   logic signed [61:0] pr_ff [4];
   logic signed [34:0] pn1_ff, pn2_ff;
   logic [35:0]        adp;
   logic [62:0]        ps1, ps2;
   logic [dcr_pkg::NUM_W-1:0] num1_ff, num2_ff;

   always_comb begin
      ps1 = {pr_ff[0][61], pr_ff[0]} + {pr_ff[1][61], pr_ff[1]};
      ps2 = {pr_ff[2][61], pr_ff[2]} + {pr_ff[3][61], pr_ff[3]};
      adp = dp_ff[35] ? 36'(-dp_ff) : 36'(dp_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_ff[0] <= carry_ff[dcr_pkg::ST_PROD-1].v1x * nx_c;
         pr_ff[1] <= carry_ff[dcr_pkg::ST_PROD-1].v1y * ny_c;
         pr_ff[2] <= carry_ff[dcr_pkg::ST_PROD-1].v2x * nx_c;
         pr_ff[3] <= carry_ff[dcr_pkg::ST_PROD-1].v2y * ny_c;
         pn1_ff   <= ps1[62:dcr_pkg::FRAC_N];
         pn2_ff   <= ps2[62:dcr_pkg::FRAC_N];
         dp_ff    <= {pn2_ff[34], pn2_ff} - {pn1_ff[34], pn1_ff};
         num1_ff  <= {carry_ff[dcr_pkg::ST_NUM-1].m2, 1'b0} * adp;
         num2_ff  <= {carry_ff[dcr_pkg::ST_NUM-1].m1, 1'b0} * adp;
      end
   end

   // ------------------------------------------------------------------------------------
   // Impulse divide by the mass sum, on magnitudes, one quotient bit per stage.
   // The sign is applied afterwards, which gives truncation toward zero.
   // ------------------------------------------------------------------------------------
   logic [dcr_pkg::NUM_W-1:0]    kr1_ff [dcr_pkg::KQ_STEPS];
   logic [dcr_pkg::NUM_W-1:0]    kr2_ff [dcr_pkg::KQ_STEPS];
   logic [dcr_pkg::KQ_STEPS-1:0] kq1_ff [dcr_pkg::KQ_STEPS];
   logic [dcr_pkg::KQ_STEPS-1:0] kq2_ff [dcr_pkg::KQ_STEPS];
   logic [dcr_pkg::NUM_W-1:0]    kr1_in [dcr_pkg::KQ_STEPS];
   logic [dcr_pkg::NUM_W-1:0]    kr2_in [dcr_pkg::KQ_STEPS];
   logic [dcr_pkg::KQ_STEPS-1:0] kq1_in [dcr_pkg::KQ_STEPS];
   logic [dcr_pkg::KQ_STEPS-1:0] kq2_in [dcr_pkg::KQ_STEPS];

   for (genvar j = 0; j < dcr_pkg::KQ_STEPS; j++) begin : g_kdiv
      localparam int Sh = dcr_pkg::KQ_STEPS - 1 - j;
      logic [dcr_pkg::NUM_W-1:0]    r1_cur, r2_cur, dsh;
      logic [dcr_pkg::KQ_STEPS-1:0] q1_cur, q2_cur;

      if (j == 0) begin : g_first
         assign r1_cur = num1_ff;
         assign r2_cur = num2_ff;
         assign q1_cur = '0;
         assign q2_cur = '0;
      end else begin : g_next
         assign r1_cur = kr1_ff[j-1];
         assign r2_cur = kr2_ff[j-1];
         assign q1_cur = kq1_ff[j-1];
         assign q2_cur = kq2_ff[j-1];
      end

      always_comb begin
         dsh = dcr_pkg::NUM_W'(carry_ff[dcr_pkg::ST_KDIV0+j-1].msum) << Sh;
         if (r1_cur >= dsh) begin
            kr1_in[j] = r1_cur - dsh;
            kq1_in[j] = q1_cur | (dcr_pkg::KQ_STEPS'(1) << Sh);
         end else begin
            kr1_in[j] = r1_cur;
            kq1_in[j] = q1_cur;
         end
         if (r2_cur >= dsh) begin
            kr2_in[j] = r2_cur - dsh;
            kq2_in[j] = q2_cur | (dcr_pkg::KQ_STEPS'(1) << Sh);
         end else begin
            kr2_in[j] = r2_cur;
            kq2_in[j] = q2_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < dcr_pkg::KQ_STEPS; j++) begin
            kr1_ff[j] <= kr1_in[j];
            kr2_ff[j] <= kr2_in[j];
            kq1_ff[j] <= kq1_in[j];
            kq2_ff[j] <= kq2_in[j];
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Velocity change along the normal: n * k, then v + floor(n * k / 2^28), saturated.
   // A fixed disc, coincident centres or a zero mass sum leave the velocity as it came.
   // ------------------------------------------------------------------------------------
   logic signed [36:0] k1_c, k2_c;
   logic signed [66:0] mp_ff [4];

   always_comb begin
      k1_c = {1'b0, kq1_ff[dcr_pkg::KQ_STEPS-1]};
      k2_c = {1'b0, kq2_ff[dcr_pkg::KQ_STEPS-1]};
      if (carry_ff[dcr_pkg::ST_KPROD-1].kn1) begin
         k1_c = -k1_c;
      end
      if (carry_ff[dcr_pkg::ST_KPROD-1].kn2) begin
         k2_c = -k2_c;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mp_ff[0] <= carry_ff[dcr_pkg::ST_KPROD-1].nx * k1_c;
         mp_ff[1] <= carry_ff[dcr_pkg::ST_KPROD-1].ny * k1_c;
         mp_ff[2] <= carry_ff[dcr_pkg::ST_KPROD-1].nx * k2_c;
         mp_ff[3] <= carry_ff[dcr_pkg::ST_KPROD-1].ny * k2_c;
      end
   end

   dcr_pkg::carry_type co;
   logic signed [39:0] s1x, s1y, s2x, s2y;
   logic signed [31:0] o1x_in, o1y_in, o2x_in, o2y_in;
   logic signed [31:0] o1x_ff, o1y_ff, o2x_ff, o2y_ff;
   logic               ocoin_ff;

   always_comb begin
      co  = carry_ff[dcr_pkg::ST_OUT-1];
      s1x = {{8{co.v1x[31]}}, co.v1x} + {mp_ff[0][66], mp_ff[0][66:dcr_pkg::FRAC_N]};
      s1y = {{8{co.v1y[31]}}, co.v1y} + {mp_ff[1][66], mp_ff[1][66:dcr_pkg::FRAC_N]};
      s2x = {{8{co.v2x[31]}}, co.v2x} + {mp_ff[2][66], mp_ff[2][66:dcr_pkg::FRAC_N]};
      s2y = {{8{co.v2y[31]}}, co.v2y} + {mp_ff[3][66], mp_ff[3][66:dcr_pkg::FRAC_N]};
      o1x_in = co.v1x;
      o1y_in = co.v1y;
      o2x_in = co.v2x;
      o2y_in = co.v2y;
      if (!co.skip && co.mov1) begin
         o1x_in = dcr_pkg::sat32(s1x);
         o1y_in = dcr_pkg::sat32(s1y);
      end
      if (!co.skip && co.mov2) begin
         o2x_in = dcr_pkg::sat32(s2x);
         o2y_in = dcr_pkg::sat32(s2y);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o1x_ff   <= o1x_in;
         o1y_ff   <= o1y_in;
         o2x_ff   <= o2x_in;
         o2y_ff   <= o2y_in;
         ocoin_ff <= co.coin;
      end
   end

   assign rsp_ch.valid            = valid_ff[dcr_pkg::DEPTH-1];
   assign rsp_ch.new_first_vel_x  = o1x_ff;
   assign rsp_ch.new_first_vel_y  = o1y_ff;
   assign rsp_ch.new_second_vel_x = o2x_ff;
   assign rsp_ch.new_second_vel_y = o2y_ff;
   assign rsp_ch.coincident       = ocoin_ff;

endmodule

`default_nettype wire

/* rtl/dcr_checker.sv */
// Port-level assertions for the disc collision response top level, and the bind that
// attaches them. Depends on disc_elastic_collision_response_top.
`timescale 1ns / 1ps
`default_nettype none

module dcr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_v1x,
   input wire logic [31:0] rsp_v1y,
   input wire logic [31:0] rsp_v2x,
   input wire logic [31:0] rsp_v2y,
   input wire logic        rsp_coin
);

   // A stalled response transaction stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response transaction keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_v1x) && $stable(rsp_v1y)
                                && $stable(rsp_v2x) && $stable(rsp_v2y) && $stable(rsp_coin))
      else $error("response payload changed while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response offered straight after reset");

   // With nothing waiting at the output the block always takes a request.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with an empty output");

   // A stalled output freezes the whole pipeline, so no request may enter.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while the output is stalled");

endmodule

bind disc_elastic_collision_response_top dcr_checker u_dcr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_v1x   (rsp_ch.new_first_vel_x),
   .rsp_v1y   (rsp_ch.new_first_vel_y),
   .rsp_v2x   (rsp_ch.new_second_vel_x),
   .rsp_v2y   (rsp_ch.new_second_vel_y),
   .rsp_coin  (rsp_ch.coincident)
);

`default_nettype wire
